/* hw/rtl/blsp_pkg.sv */
// Shared types and constants of the binary-load segment parser.
package blsp_pkg;

  // Largest number of data bytes in one chunk.
  localparam int unsigned CHUNK_BYTES = 1024;
  localparam int unsigned ChunkOffW   = $clog2(CHUNK_BYTES);
  localparam logic [ChunkOffW-1:0] ChunkOffLast = ChunkOffW'(CHUNK_BYTES - 1);

  localparam logic [15:0] HeaderWord = 16'hFFFF;
  localparam logic [15:0] CountMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_LAST_BYTE = 2'd1,
    OP_EOF       = 2'd2,
    OP_EOF_ALT   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    OUT_PARSING = 3'd0,
    OUT_OK      = 3'd1,
    OUT_WARN    = 3'd2,
    OUT_FAIL    = 3'd3,
    OUT_IGNORED = 3'd4
  } outcome_e;

  typedef enum logic [3:0] {
    PH_HDR_LO   = 4'd0,
    PH_HDR_HI   = 4'd1,
    PH_START_LO = 4'd2,
    PH_START_HI = 4'd3,
    PH_END_LO   = 4'd4,
    PH_END_HI   = 4'd5,
    PH_DATA     = 4'd6,
    PH_NEXT_LO  = 4'd7,
    PH_NEXT_HI  = 4'd8,
    PH_MARK_LO  = 4'd9,
    PH_MARK_HI  = 4'd10,
    PH_OK       = 4'd11,
    PH_WARN     = 4'd12,
    PH_FAIL     = 4'd13
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [7:0]             held_low_byte;
    logic [15:0]            current_address;
    logic [15:0]            segment_end;
    logic [ChunkOffW-1:0]   chunk_offset;
    logic [15:0]            chunk_total;
    logic [15:0]            chunk_index;
  } state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic [15:0] load_address;
    logic [15:0] chunk_number;
    logic       chunk_first;
    outcome_e   outcome;
  } result_t;

  function automatic logic phase_done(phase_e ph);
    return (ph == PH_OK) || (ph == PH_WARN) || (ph == PH_FAIL);
  endfunction

endpackage

/* hw/rtl/blsp_step.sv */
// Next-state and result logic for one file byte or end-of-file transaction.
module blsp_step import blsp_pkg::*; (
  input  state_t     state_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] in_byte_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic        has_byte;
  logic        eof;
  logic [15:0] word;
  state_t      mid;
  result_t     res;

  assign has_byte = (opcode_i == OP_BYTE) || (opcode_i == OP_LAST_BYTE);
  assign eof      = (opcode_i != OP_BYTE);
  assign word     = {in_byte_i, state_i.held_low_byte};

  always_comb begin
    mid = state_i;
    res = '0;
    res.outcome = OUT_PARSING;

    if (phase_done(state_i.phase)) begin
      res.outcome = OUT_IGNORED;
    end else begin
      if (has_byte) begin
        case (state_i.phase)
          PH_HDR_LO, PH_START_LO, PH_END_LO, PH_NEXT_LO, PH_MARK_LO: begin
            mid.held_low_byte = in_byte_i;
            mid.phase = phase_e'(state_i.phase + 4'd1);
          end
          PH_HDR_HI: begin
            mid.phase = (word == HeaderWord) ? PH_START_LO : PH_FAIL;
          end
          PH_START_HI, PH_MARK_HI: begin
            mid.current_address = word;
            mid.phase = PH_END_LO;
          end
          PH_END_HI: begin
            mid.segment_end = word;
            if (word < state_i.current_address) begin
              mid.phase = PH_WARN;
            end else begin
              mid.chunk_offset = '0;
              mid.phase = PH_DATA;
            end
          end
          PH_NEXT_HI: begin
            if (word == HeaderWord) begin
              mid.phase = PH_MARK_LO;
            end else begin
              mid.current_address = word;
              mid.phase = PH_END_LO;
            end
          end
          PH_DATA: begin
            if (state_i.chunk_offset == '0) begin
              res.chunk_first = 1'b1;
              mid.chunk_index = state_i.chunk_total;
              if (state_i.chunk_total != CountMax) begin
                mid.chunk_total = state_i.chunk_total + 16'd1;
              end
            end
            res.byte_valid   = 1'b1;
            res.out_byte     = in_byte_i;
            res.load_address = state_i.current_address;
            res.chunk_number = mid.chunk_index;
            mid.chunk_offset = (state_i.chunk_offset == ChunkOffLast) ? '0 :
                               state_i.chunk_offset + 1'b1;
            if (state_i.current_address == state_i.segment_end) begin
              mid.phase = PH_NEXT_LO;
            end
            mid.current_address = state_i.current_address + 16'd1;
          end
          default: begin
          end
        endcase
      end

      // End of file is applied after the byte, so a last byte may finish the file.
      if (eof && !phase_done(mid.phase)) begin
        case (mid.phase)
          PH_HDR_LO, PH_HDR_HI, PH_START_LO, PH_START_HI: begin
            mid.phase = PH_FAIL;
          end
          PH_END_LO, PH_END_HI: begin
            mid.phase = (mid.chunk_total == '0) ? PH_FAIL : PH_WARN;
          end
          PH_NEXT_LO: begin
            mid.phase = PH_OK;
          end
          default: begin
            mid.phase = PH_WARN;
          end
        endcase
      end

      case (mid.phase)
        PH_OK:   res.outcome = OUT_OK;
        PH_WARN: res.outcome = OUT_WARN;
        PH_FAIL: res.outcome = OUT_FAIL;
        default: res.outcome = OUT_PARSING;
      endcase
    end
  end

  assign state_o  = mid;
  assign result_o = res;

endmodule

/* hw/rtl/binary_load_segment_parser.sv */
// Top level of the binary-load segment parser with its result register.
// The parser takes one byte of an executable file per transaction and gives exactly one
// result per transaction: the data byte with its load address and chunk number, or
// just the parse outcome. It accepts a transaction in every cycle in which no result waits
// or the downstream side takes the waiting one; the result register gives each result in the
// cycle after its transaction is taken; a new result may replace it as it is taken.
// After the parse finishes, every further transaction returns the ignored outcome.
module binary_load_segment_parser import blsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] load_address_o,
  output logic [15:0] chunk_number_o,
  output logic        chunk_first_o,
  output logic [2:0]  outcome_o
);

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  blsp_step u_step (
    .state_i  (state_q),
    .opcode_i (opcode_i),
    .in_byte_i(in_byte_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_HDR_LO, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_valid_o   = res_q.byte_valid;
  assign out_byte_o     = res_q.out_byte;
  assign load_address_o = res_q.load_address;
  assign chunk_number_o = res_q.chunk_number;
  assign chunk_first_o  = res_q.chunk_first;
  assign outcome_o      = res_q.outcome;

  // A finished parse never restarts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_done(state_q.phase) |=> phase_done(state_q.phase))
    else $error("parser left a finished phase");

  // A transaction taken after the parse finished yields the ignored outcome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_done(state_q.phase) |=>
      out_valid_o && !byte_valid_o && (outcome_o == OUT_IGNORED))
    else $error("transaction after finish not ignored");

  // A data byte never comes with a failed or ignored outcome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> (outcome_o != OUT_FAIL) && (outcome_o != OUT_IGNORED))
    else $error("data byte with failed or ignored outcome");

  // The chunk count only grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> state_q.chunk_total >= $past(state_q.chunk_total))
    else $error("chunk count went down");

endmodule
